// ----- design/qmlp_pkg.sv -----
// qmlp_pkg: shared types and constants for the quantized perceptron head
// no dependencies
`default_nettype none
package qmlp_pkg;
    localparam int ACC_W = 32;
    localparam int RES_W = 14;
    localparam int IDX_W = 5;

    // output post-processing class
    typedef enum logic [3:0] {
        PP_HIDDEN = 4'b0001,
        PP_QUIET  = 4'b0010,
        PP_LATENT = 4'b0100,
        PP_TEMP   = 4'b1000
    } pp_t;

    // hidden activation: (s+32)>>6 clamped 0..127
    function automatic logic [6:0] act_hidden(input logic signed [31:0] s);
        logic signed [32:0] t;
        logic signed [26:0] q;
        t = {s[31], s} + 33'sd32;
        q = t[32:6];
        if (q < 0) return 7'd0;
        else if (q > 27'sd127) return 7'd127;
        else return q[6:0];
    endfunction

    // quiet output: (s+8)>>4 clamped -1024..1024
    function automatic logic signed [13:0] act_quiet(input logic signed [31:0] s);
        logic signed [32:0] t;
        logic signed [28:0] q;
        t = {s[31], s} + 33'sd8;
        q = t[32:4];
        if (q < -29'sd1024) return -14'sd1024;
        else if (q > 29'sd1024) return 14'sd1024;
        else return q[13:0];
    endfunction

    // latent output: (s+32)>>6 clamped -127..127
    function automatic logic signed [13:0] act_latent(input logic signed [31:0] s);
        logic signed [32:0] t;
        logic signed [26:0] q;
        t = {s[31], s} + 33'sd32;
        q = t[32:6];
        if (q < -27'sd127) return -14'sd127;
        else if (q > 27'sd127) return 14'sd127;
        else return q[13:0];
    endfunction

    // temperature: t = s/4096 truncating, clamp +-64, 1024-16t clamped 256..4096
    function automatic logic signed [13:0] act_temp(input logic signed [31:0] s);
        logic signed [19:0] q;
        logic signed [19:0] v;
        q = s[31:12];
        if (s[31] && (s[11:0] != 12'd0)) q = q + 20'sd1;
        if (q < -20'sd64) q = -20'sd64;
        else if (q > 20'sd64) q = 20'sd64;
        v = 20'sd1024 - (q <<< 4);
        if (v < 20'sd256) v = 20'sd256;
        else if (v > 20'sd4096) v = 20'sd4096;
        return v[13:0];
    endfunction
endpackage
`default_nettype wire

// ----- design/qmlp_mac.sv -----
// qmlp_mac: registered multiply-accumulate unit with wrapping 32-bit sum
// depends on qmlp_pkg
`default_nettype none
module qmlp_mac (
    input  wire logic                      aclk,
    input  wire logic                      load,
    input  wire logic signed [31:0]        load_value,
    input  wire logic                      mac_en,
    input  wire logic signed [15:0]        weight,
    input  wire logic signed [8:0]         operand,
    output logic signed [31:0]             acc
);
    import qmlp_pkg::*;
    logic signed [31:0] acc_reg;
    logic signed [24:0] prod_reg;
    logic               prod_vld_reg;

    // product register then accumulate
    always_ff @(posedge aclk) begin
        prod_reg     <= weight * operand;
        prod_vld_reg <= mac_en;
        if (load) begin
            acc_reg <= load_value;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + {{7{prod_reg[24]}}, prod_reg};
        end
    end
    assign acc = acc_reg;
endmodule
`default_nettype wire

// ----- design/qmlp_seq.sv -----
// qmlp_seq: parameter memories, activation memories and evaluation sequencer
// depends on qmlp_pkg, qmlp_mac
`default_nettype none
module qmlp_seq #(
    parameter int IN_DIM      = 16,
    parameter int HIDDEN_DIM  = 32,
    parameter int QUIET_OUTS  = 10,
    parameter int LATENT_OUTS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [11:0]                   wr_addr,
    input  wire logic signed [31:0]            wr_value,
    input  wire logic                          feat_en,
    input  wire logic signed [7:0]             feat_value,
    input  wire logic                          enabled,
    output logic                               busy,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic [qmlp_pkg::IDX_W-1:0]         res_index,
    output logic signed [qmlp_pkg::RES_W-1:0]  res_value,
    output logic                               res_last
);
    import qmlp_pkg::*;

    localparam int OUT_DIM = QUIET_OUTS + LATENT_OUTS + 2;
    localparam int A_W0 = HIDDEN_DIM;
    localparam int A_B1 = A_W0 + HIDDEN_DIM * IN_DIM;
    localparam int A_W1 = A_B1 + HIDDEN_DIM;
    localparam int A_B2 = A_W1 + HIDDEN_DIM * HIDDEN_DIM;
    localparam int A_W2 = A_B2 + OUT_DIM;
    localparam int A_END = A_W2 + OUT_DIM * HIDDEN_DIM;
    localparam int NB = 2 * HIDDEN_DIM + OUT_DIM;
    localparam int NW = A_END - NB;
    localparam int WA_W = $clog2(NW);
    localparam int BA_W = $clog2(NB);
    localparam int MAXI = (IN_DIM > HIDDEN_DIM) ? IN_DIM : HIDDEN_DIM;
    localparam int I_W = $clog2(MAXI + 1);
    localparam int MAXJ = (HIDDEN_DIM > OUT_DIM) ? HIDDEN_DIM : OUT_DIM;
    localparam int J_W = $clog2(MAXJ + 1);
    localparam int F_W = $clog2(IN_DIM + 1);
    localparam int H_W = (HIDDEN_DIM > 1) ? $clog2(HIDDEN_DIM) : 1;
    localparam int FB_W = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_BIAS = 5'b00010,
        ST_MAC  = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    // weights stored in one flat memory: w0, w1, w2
    logic signed [15:0] wmem [NW];
    logic signed [31:0] bmem [NB];
    logic signed [7:0]  fmem [IN_DIM];
    logic [6:0]         h1mem [HIDDEN_DIM];
    logic [6:0]         h2mem [HIDDEN_DIM];

    state_t state_reg, state_next;
    logic [1:0]     layer_reg, layer_next;
    logic [J_W-1:0] j_reg, j_next;
    logic [I_W-1:0] i_reg, i_next;
    logic [WA_W-1:0] wptr_reg, wptr_next;
    logic [BA_W-1:0] bptr_reg, bptr_next;
    logic [F_W-1:0] fcnt_reg;
    logic [2:0]     drain_reg, drain_next;
    logic           ovld_reg;
    logic [IDX_W-1:0] oidx_reg;
    logic signed [RES_W-1:0] oval_reg;
    logic           olast_reg;

    logic signed [15:0] w_rd;
    logic signed [31:0] b_rd;
    logic signed [8:0]  x_rd;
    logic               mac_en_reg;
    logic               load_reg;
    logic signed [31:0] acc;
    logic [I_W-1:0]     width_cur;
    logic [J_W-1:0]     rows_cur;
    logic [WA_W:0]      woff;
    logic               start;

    // parameter writes and memory reads
    always_ff @(posedge aclk) begin
        if (wr_en && wr_addr < A_END[11:0]) begin
            if (wr_addr < A_W0[11:0]) begin
                bmem[BA_W'(wr_addr)] <= wr_value;
            end else if (wr_addr < A_B1[11:0]) begin
                wmem[WA_W'(wr_addr - A_W0[11:0])] <= wr_value[15:0];
            end else if (wr_addr < A_W1[11:0]) begin
                bmem[BA_W'(wr_addr - A_B1[11:0] + 12'(HIDDEN_DIM))] <= wr_value;
            end else if (wr_addr < A_B2[11:0]) begin
                wmem[WA_W'(wr_addr - A_W1[11:0] + 12'(HIDDEN_DIM * IN_DIM))] <= wr_value[15:0];
            end else if (wr_addr < A_W2[11:0]) begin
                bmem[BA_W'(wr_addr - A_B2[11:0] + 12'(2 * HIDDEN_DIM))] <= wr_value;
            end else begin
                wmem[WA_W'(wr_addr - A_W2[11:0]
                     + 12'(HIDDEN_DIM * IN_DIM + HIDDEN_DIM * HIDDEN_DIM))] <= wr_value[15:0];
            end
        end
        w_rd <= wmem[wptr_reg];
        b_rd <= bmem[bptr_reg];
        case (layer_reg)
            2'd0:    x_rd <= {fmem[FB_W'(i_reg)][7], fmem[FB_W'(i_reg)]};
            2'd1:    x_rd <= {2'b00, h1mem[H_W'(i_reg)]};
            default: x_rd <= {2'b00, h2mem[H_W'(i_reg)]};
        endcase
    end

    // feature buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcnt_reg <= '0;
        end else if (feat_en) begin
            if (fcnt_reg >= F_W'(IN_DIM - 1)) fcnt_reg <= '0;
            else fcnt_reg <= fcnt_reg + 1'b1;
        end
        if (feat_en && fcnt_reg < F_W'(IN_DIM)) fmem[FB_W'(fcnt_reg)] <= feat_value;
    end
    assign start = feat_en && (fcnt_reg >= F_W'(IN_DIM - 1)) && enabled;

    assign width_cur = (layer_reg == 2'd0) ? I_W'(IN_DIM) : I_W'(HIDDEN_DIM);
    assign rows_cur  = (layer_reg == 2'd2) ? J_W'(OUT_DIM) : J_W'(HIDDEN_DIM);
    assign woff      = '0;

    qmlp_mac u_mac (
        .aclk       (aclk),
        .load       (load_reg),
        .load_value (b_rd),
        .mac_en     (mac_en_reg),
        .weight     (w_rd),
        .operand    (x_rd),
        .acc        (acc)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        layer_next = layer_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        wptr_next  = wptr_reg;
        bptr_next  = bptr_reg;
        drain_next = drain_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_BIAS;
                    layer_next = 2'd0;
                    j_next = '0;
                    i_next = '0;
                    wptr_next = '0;
                    bptr_next = '0;
                end
            end
            ST_BIAS: begin
                state_next = ST_MAC;
            end
            ST_MAC: begin
                wptr_next = wptr_reg + 1'b1;
                if (i_reg == width_cur - 1'b1) begin
                    state_next = ST_WAIT;
                    drain_next = 3'd3;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                if (drain_reg != 3'd0) begin
                    drain_next = drain_reg - 1'b1;
                end else if (layer_reg == 2'd2) begin
                    state_next = ST_OUT;
                end else begin
                    i_next = '0;
                    bptr_next = bptr_reg + 1'b1;
                    if (j_reg == rows_cur - 1'b1) begin
                        j_next = '0;
                        layer_next = layer_reg + 1'b1;
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                    state_next = ST_BIAS;
                end
            end
            ST_OUT: begin
                if (!ovld_reg || res_ready) begin
                    i_next = '0;
                    bptr_next = bptr_reg + 1'b1;
                    if (j_reg == rows_cur - 1'b1) begin
                        state_next = ST_IDLE;
                    end else begin
                        j_next = j_reg + 1'b1;
                        state_next = ST_BIAS;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mac_en_reg <= 1'b0;
            load_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mac_en_reg <= (state_reg == ST_MAC);
            load_reg   <= (state_reg == ST_BIAS);
        end
        layer_reg <= layer_next;
        j_reg     <= j_next;
        i_reg     <= i_next;
        wptr_reg  <= wptr_next + WA_W'(woff);
        bptr_reg  <= bptr_next;
        drain_reg <= drain_next;
        // hidden write-back at end of drain
        if (state_reg == ST_WAIT && drain_reg == 3'd0) begin
            if (layer_reg == 2'd0) h1mem[H_W'(j_reg)] <= act_hidden(acc);
            if (layer_reg == 2'd1) h2mem[H_W'(j_reg)] <= act_hidden(acc);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovld_reg <= 1'b0;
        end else if (state_reg == ST_OUT && (!ovld_reg || res_ready)) begin
            ovld_reg <= 1'b1;
        end else if (res_ready) begin
            ovld_reg <= 1'b0;
        end
        if (state_reg == ST_OUT && (!ovld_reg || res_ready)) begin
            oidx_reg  <= IDX_W'(j_reg);
            olast_reg <= (j_reg == J_W'(OUT_DIM - 1));
            if (j_reg < J_W'(QUIET_OUTS)) oval_reg <= act_quiet(acc);
            else if (j_reg < J_W'(QUIET_OUTS + LATENT_OUTS)) oval_reg <= act_latent(acc);
            else oval_reg <= act_temp(acc);
        end
    end

    assign busy      = (state_reg != ST_IDLE) || ovld_reg;
    assign res_valid = ovld_reg;
    assign res_index = oidx_reg;
    assign res_value = oval_reg;
    assign res_last  = olast_reg;

    property p_idle_no_mac;
        @(posedge aclk) disable iff (!aresetn) (state_reg == ST_IDLE) |=> !load_reg;
    endproperty
    a_idle_no_mac: assert property (p_idle_no_mac) else $error("load outside evaluation");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovld_reg && !res_ready) |=> (ovld_reg && $stable(oval_reg)))
        else $error("result changed while stalled");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BIAS) |-> (layer_reg != 2'd3))
        else $error("bad layer");
endmodule
`default_nettype wire

// ----- design/quantized_mlp_three_layer_head_core.sv -----
// quantized_mlp_three_layer_head_core: top level of the perceptron head
// depends on qmlp_pkg, qmlp_seq
`default_nettype none
// The last feature of a set starts an evaluation, when enabled, that runs every
// dot product through one shared multiply-accumulate unit fed from the weight
// and bias memories; a stalled result holds the evaluation until it is taken.
// No input transaction is accepted while an evaluation or its results are
// pending.
module quantized_mlp_three_layer_head_core #(
    parameter int IN_DIM      = 16,
    parameter int HIDDEN_DIM  = 32,
    parameter int QUIET_OUTS  = 10,
    parameter int LATENT_OUTS = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_func,
    input  wire logic [11:0]        s_word_address,
    input  wire logic signed [31:0] s_word_value,
    input  wire logic signed [7:0]  s_feature_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [4:0]              m_result_index,
    output logic signed [13:0]      m_result_value,
    output logic                    m_result_last
);
    import qmlp_pkg::*;
    logic enabled_reg;
    logic busy;
    logic acc_in;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) enabled_reg <= 1'b0;
        else if (cfg_valid) enabled_reg <= cfg_data;
    end

    assign s_ready = !busy;
    assign acc_in  = s_valid && s_ready;

    qmlp_seq #(
        .IN_DIM(IN_DIM), .HIDDEN_DIM(HIDDEN_DIM),
        .QUIET_OUTS(QUIET_OUTS), .LATENT_OUTS(LATENT_OUTS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (acc_in && !s_func),
        .wr_addr    (s_word_address),
        .wr_value   (s_word_value),
        .feat_en    (acc_in && s_func),
        .feat_value (s_feature_value),
        .enabled    (enabled_reg),
        .busy       (busy),
        .res_valid  (m_valid),
        .res_ready  (m_ready),
        .res_index  (m_result_index),
        .res_value  (m_result_value),
        .res_last   (m_result_last)
    );
endmodule
`default_nettype wire
